FILE: rtl/longest_prefix_match_lookup_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the route lookup block
// Shared property forms, clocked on clk_i and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef LONGEST_PREFIX_MATCH_LOOKUP_ASSERT_SVH
`define LONGEST_PREFIX_MATCH_LOOKUP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define LPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lpm_pkg.sv
// ----------------------------------------------------------------------------
// lpm_pkg
// Types and constants shared by the route lookup controller and datapath.
// ----------------------------------------------------------------------------
package lpm_pkg;

  // Default table depth and number of output interfaces
  localparam int RouteEntries = 16;
  localparam int NumPorts     = 4;

  // Fixed field widths
  localparam int IdxFieldW = 4;
  localparam int AddrW     = 32;
  localparam int PortW     = 2;

  typedef enum logic {
    ReqWrite  = 1'b0,
    ReqLookup = 1'b1
  } req_type_e;

  // One request
  typedef struct packed {
    req_type_e            req_type;
    logic [IdxFieldW-1:0] entry_index;
    logic                 entry_valid;
    logic [AddrW-1:0]     entry_prefix;
    logic [AddrW-1:0]     entry_mask;
    logic [PortW-1:0]     entry_port;
    logic [AddrW-1:0]     lookup_addr;
  } lpm_req_t;

  // One lookup result
  typedef struct packed {
    logic                 hit;
    logic [IdxFieldW-1:0] match_index;
    logic [PortW-1:0]     out_port;
  } lpm_rsp_t;

  // One stored route
  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] prefix;
    logic [AddrW-1:0] mask;
    logic [PortW-1:0] port;
  } lpm_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;    // write an empty entry at the counter, advance
    logic wr_en;     // write the request's entry
    logic start;     // latch address, clear best, rewind counter
    logic rd_en;     // read the entry at the counter, advance
    logic out_load;  // move the best match into the output register
  } lpm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_last;  // counter sits on the last table slot
    logic out_free;  // output register can take a result this cycle
  } lpm_sts_t;

endpackage

FILE: rtl/lpm_ctrl.sv
// ----------------------------------------------------------------------------
// lpm_ctrl
// Sequencer for table clearing, entry writes and lookup scans.
// ----------------------------------------------------------------------------
module lpm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  lpm_pkg::req_type_e  req_type_i,
  output logic                in_stall_o,
  input  lpm_pkg::lpm_sts_t   sts_i,
  output lpm_pkg::lpm_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    ClearSt,
    IdleSt,
    ScanSt,
    LastSt,
    DoneSt
  } state_e;

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ClearSt;
    end else begin
      state_q <= state_d;
    end
  end

  // Decode commands and next state
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ClearSt: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = IdleSt;
        end
      end
      IdleSt: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (req_type_i == lpm_pkg::ReqWrite) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = ScanSt;
          end
        end
      end
      ScanSt: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = LastSt;
        end
      end
      LastSt: begin
        // last entry is compared in the datapath this cycle
        state_d = DoneSt;
      end
      DoneSt: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = IdleSt;
        end
      end
      default: begin
        state_d = ClearSt;
      end
    endcase
  end

endmodule

FILE: rtl/lpm_dpath.sv
// ----------------------------------------------------------------------------
// lpm_dpath
// Route table memory, slot counter, best-match tracker and output register.
// ----------------------------------------------------------------------------
module lpm_dpath #(
  parameter int ROUTE_ENTRIES = lpm_pkg::RouteEntries
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpm_pkg::lpm_req_t in_req_i,
  input  lpm_pkg::lpm_cmd_t cmd_i,
  output lpm_pkg::lpm_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lpm_pkg::lpm_rsp_t out_rsp_o
);

  localparam int IdxW  = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int WideW = (IdxW > lpm_pkg::IdxFieldW) ? IdxW : lpm_pkg::IdxFieldW;

  lpm_pkg::lpm_entry_t mem [ROUTE_ENTRIES];

  logic [IdxW-1:0]           cnt_q;
  lpm_pkg::lpm_entry_t       rd_q;
  logic [IdxW-1:0]           rd_idx_q;
  logic                      rd_vld_q;
  logic [lpm_pkg::AddrW-1:0] addr_q;
  logic                      found_q;
  logic [lpm_pkg::AddrW-1:0] best_mask_q;
  logic [IdxW-1:0]           best_idx_q;
  logic [lpm_pkg::PortW-1:0] best_port_q;
  logic                      out_valid_q;
  lpm_pkg::lpm_rsp_t         out_rsp_q;

  logic [WideW-1:0]          wr_idx_wide;
  logic                      wr_ok;
  logic [lpm_pkg::PortW-1:0] port_sat;
  logic                      mem_we;
  logic [IdxW-1:0]           mem_waddr;
  lpm_pkg::lpm_entry_t       mem_wdata;
  logic                      match;
  logic                      better;

  // Range-check the slot and saturate the port of a written entry
  assign wr_idx_wide = WideW'(in_req_i.entry_index);
  assign wr_ok = cmd_i.wr_en && (32'(in_req_i.entry_index) < 32'(ROUTE_ENTRIES));
  assign port_sat = (32'(in_req_i.entry_port) >= 32'(lpm_pkg::NumPorts)) ?
                    lpm_pkg::PortW'(lpm_pkg::NumPorts - 1) : in_req_i.entry_port;

  // Select the single write port: clearing sweep or request write
  always_comb begin
    mem_we    = cmd_i.clr_en || wr_ok;
    mem_waddr = wr_idx_wide[IdxW-1:0];
    mem_wdata = '{valid:  in_req_i.entry_valid,
                  prefix: in_req_i.entry_prefix,
                  mask:   in_req_i.entry_mask,
                  port:   port_sat};
    if (cmd_i.clr_en) begin
      mem_waddr = cnt_q;
      mem_wdata = '0;
    end
  end

  // Write the table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Read one entry per scan cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q     <= mem[cnt_q];
      rd_idx_q <= cnt_q;
    end
  end

  // Advance the slot counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.start) begin
        cnt_q <= '0;
      end else if (cmd_i.clr_en || cmd_i.rd_en) begin
        cnt_q <= cnt_q + IdxW'(1);
      end
    end
  end

  // Match the read entry and rank it against the best so far
  assign match  = rd_q.valid && (((rd_q.prefix ^ addr_q) & rd_q.mask) == '0);
  assign better = !found_q || (rd_q.mask > best_mask_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.start) begin
      found_q <= 1'b0;
    end else if (rd_vld_q && match) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      addr_q <= in_req_i.lookup_addr;
    end
    if (rd_vld_q && match && better) begin
      best_mask_q <= rd_q.mask;
      best_idx_q  <= rd_idx_q;
      best_port_q <= rd_q.port;
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (found_q) begin
        out_rsp_q <= '{hit:         1'b1,
                       match_index: lpm_pkg::IdxFieldW'(best_idx_q),
                       out_port:    best_port_q};
      end else begin
        out_rsp_q <= '0;
      end
    end
  end

  assign sts_o.cnt_last = (cnt_q == IdxW'(ROUTE_ENTRIES - 1));
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_rsp_o      = out_rsp_q;

endmodule

FILE: rtl/longest_prefix_match_lookup.sv
// ----------------------------------------------------------------------------
// longest_prefix_match_lookup
// IPv4 route table with longest-prefix-match lookup over a scanned memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | sink      | in_valid_i / in_stall_o  | in_req_i  (lpm_req_t)
//  out     | source    | out_valid_o / out_stall_i | out_rsp_o (lpm_rsp_t)
//
//  A write request is stored as it is accepted and gives no response.
//  A lookup steps through accept, one table read per entry through the single
//  memory read port, the last compare and the result load.
//  After reset a clearing pass empties the table; in_stall_o stays high
//  throughout it.
//  A finished result waits in the output register while the next request
//  is accepted; a lookup stalls at its end only while a stalled result fills it.
// ----------------------------------------------------------------------------
module longest_prefix_match_lookup #(
  parameter int ROUTE_ENTRIES = lpm_pkg::RouteEntries
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lpm_pkg::lpm_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lpm_pkg::lpm_rsp_t out_rsp_o
);

  lpm_pkg::lpm_cmd_t cmd;
  lpm_pkg::lpm_sts_t sts;

  lpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_req_i.req_type),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lpm_dpath #(
    .ROUTE_ENTRIES (ROUTE_ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

FILE: rtl/lpm_checker.sv
// ----------------------------------------------------------------------------
// lpm_checker
// Port-level checks for the route lookup block, bound to the top level.
// ----------------------------------------------------------------------------
`include "longest_prefix_match_lookup_assert.svh"

module lpm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input lpm_pkg::lpm_req_t in_req_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input lpm_pkg::lpm_rsp_t out_rsp_o
);

  logic wr_acc;
  logic lk_acc;

  assign wr_acc = in_valid_i && !in_stall_o && (in_req_i.req_type == lpm_pkg::ReqWrite);
  assign lk_acc = in_valid_i && !in_stall_o && (in_req_i.req_type == lpm_pkg::ReqLookup);

  // A stalled response holds
  `LPM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_rsp_o), "stalled response changed")

  // A miss reports zero slot and port
  `LPM_ASSERT_NOW(a_miss_zero, out_valid_o && !out_rsp_o.hit,
    (out_rsp_o.match_index == '0) && (out_rsp_o.out_port == '0), "miss with nonzero fields")

  // A write leaves the block ready for a request in the next cycle
  `LPM_ASSERT_NEXT(a_wr_ready, wr_acc, !in_stall_o, "stalled after a write request")

  // A lookup holds off further requests while it scans
  `LPM_ASSERT_NEXT(a_lk_busy, lk_acc, in_stall_o, "request taken during a scan")

endmodule

bind longest_prefix_match_lookup lpm_checker u_lpm_checker (.*);
